[rtl/i2c_mbe_pkg.sv]
`timescale 1ns / 1ps

package i2c_mbe_pkg;

	// Field widths fixed by the command and result formats
	localparam int OPCODE_W     = 3;
	localparam int BYTE_W       = 8;
	localparam int LIMIT_W      = 16;
	localparam int STATUS_W     = 2;
	localparam int BIT_CNT_W    = 4;
	localparam int RECOVER_W    = 4;
	localparam int QUEUE_DEPTH  = 2;

	// Defaults for the top-level parameters and the limit register
	localparam int DEF_RECOVER_PULSES = 9;
	localparam int DEF_TIMER_WIDTH    = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

	// Bits per byte on the wire
	localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

	// Opcodes on the command channel
	localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_START = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

	// Completion status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NACK    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

	// Classified command, as the front end hands it on
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_check;
		logic              ack_after_read;
		logic              scl;
		logic              sda;
	} tick_item_t;

	typedef struct packed {
		logic                scl_drive;
		logic                sda_drive;
		logic                ready_res;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   rx_byte;
	} result_t;

	// Bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_WAIT,
		PH_ST_CHECK,
		PH_ST_SCL_LOW,
		PH_RC_HIGH,
		PH_RC_LOW,
		PH_RC_SDA_LOW,
		PH_RC_SCL_UP,
		PH_RC_SDA_UP,
		PH_RC_CHECK,
		PH_SP_RAISE,
		PH_SP_WAIT,
		PH_SP_REL,
		PH_W_RAISE,
		PH_W_WAIT,
		PH_W_LOW,
		PH_W_DATA,
		PH_R_RAISE,
		PH_R_WAIT,
		PH_R_LOW,
		PH_R_DATA
	} phase_t;

endpackage

[rtl/i2c_mbe_if.sv]
`timescale 1ns / 1ps

interface i2c_mbe_cmd_if import i2c_mbe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   tx_byte;
	logic                ack_check;
	logic                ack_after_read;
	logic                scl_sampled;
	logic                sda_sampled;

	modport source (
		output valid, opcode, tx_byte, ack_check, ack_after_read, scl_sampled, sda_sampled,
		input  ready
	);
	modport sink (
		input  valid, opcode, tx_byte, ack_check, ack_after_read, scl_sampled, sda_sampled,
		output ready
	);
endinterface

interface i2c_mbe_res_if import i2c_mbe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                scl_drive;
	logic                sda_drive;
	logic                ready_res;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   rx_byte;

	modport source (
		output valid, scl_drive, sda_drive, ready_res, done_res, status, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, scl_drive, sda_drive, ready_res, done_res, status, rx_byte,
		output ready
	);
endinterface

[rtl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps

// Channel  Role   Handshake      Carries
// -------  -----  -------------  ------------------------------------------------
// cmd      sink   valid/ready    opcode, tx_byte, ack_check, ack_after_read,
//                                scl_sampled, sda_sampled (one half-period tick)
// res      source valid/ready    scl_drive, sda_drive, ready_res, done_res,
//                                status, rx_byte (state after that tick)
// cfg      write  cfg_we         cfg_wdata -> stretch_limit
//
// Every tick transfer yields exactly one result transfer, one tick per clock cycle
// sustained while res is ready; a tick passes the queue, then the result register.
// The front end parks classified ticks in a two-entry queue; the sequencer
// advances one phase per tick whenever its result register is free or draining.
// Reset (arst_n low) returns the sequencer to idle with both lines released
// and the stretch limit at 500; there is no clearing pass.
// A stall on res holds the sequencer; a stall on cmd only idles it.

module i2c_master_byte_engine import i2c_mbe_pkg::*; #(
	parameter int RECOVER_PULSES = DEF_RECOVER_PULSES,
	parameter int TIMER_WIDTH    = DEF_TIMER_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	i2c_mbe_cmd_if.sink        cmd,
	i2c_mbe_res_if.source      res,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	logic [LIMIT_W-1:0] stretch_limit_q;
	logic               q_valid;
	tick_item_t         q_item;
	logic               q_pop;

	// Stretch limit register; the user must write it only while the engine is quiet (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stretch_limit_q <= LIMIT_RESET;
		else if (cfg_we)
			stretch_limit_q <= cfg_wdata;
	end

	// Front end: take each tick transfer, classify the opcode, queue it
	i2c_mbe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Back end: bus sequencer, one phase per tick, registered result
	i2c_mbe_back #(
		.RECOVER_PULSES (RECOVER_PULSES),
		.TIMER_WIDTH    (TIMER_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stretch_limit (stretch_limit_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.res           (res)
	);

endmodule

[rtl/i2c_mbe_front.sv]
`timescale 1ns / 1ps

module i2c_mbe_front import i2c_mbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	i2c_mbe_cmd_if.sink       cmd,
	output logic              q_valid,
	output tick_item_t        q_item,
	input  logic              q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tick_item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	tick_item_t             item_in;
	logic                   push;

	// Classify opcode; unused codes act as a plain tick
	always_comb begin
		item_in.tx_byte        = cmd.tx_byte;
		item_in.ack_check      = cmd.ack_check;
		item_in.ack_after_read = cmd.ack_after_read;
		item_in.scl            = cmd.scl_sampled;
		item_in.sda            = cmd.sda_sampled;
		unique case (cmd.opcode)
			OP_START: item_in.cmd = CMD_START;
			OP_STOP:  item_in.cmd = CMD_STOP;
			OP_WRITE: item_in.cmd = CMD_WRITE;
			OP_READ:  item_in.cmd = CMD_READ;
			default:  item_in.cmd = CMD_TICK;
		endcase
	end

	assign cmd.ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push) - CNT_W'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= item_in;
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/i2c_mbe_back.sv]
`timescale 1ns / 1ps

module i2c_mbe_back import i2c_mbe_pkg::*; #(
	parameter int RECOVER_PULSES = DEF_RECOVER_PULSES,
	parameter int TIMER_WIDTH    = DEF_TIMER_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] stretch_limit,
	input  logic               q_valid,
	input  tick_item_t         q_item,
	output logic               q_pop,
	i2c_mbe_res_if.source      res
);

	localparam int CMP_W = (TIMER_WIDTH + 1 > LIMIT_W) ? TIMER_WIDTH + 1 : LIMIT_W;

	phase_t                   phase_q, phase_d;
	logic [BIT_CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
	logic [BYTE_W-1:0]        shift_q, shift_d;
	logic [TIMER_WIDTH-1:0]   stretch_q, stretch_d;
	logic [RECOVER_W-1:0]     recover_q, recover_d;
	logic                     ack_flag_q, ack_flag_d;
	logic                     scl_out_q, scl_out_d;
	logic                     sda_out_q, sda_out_d;
	logic [BYTE_W-1:0]        rx_hold_q, rx_hold_d;
	logic                     fin_done;
	logic [STATUS_W-1:0]      fin_status;

	logic [TIMER_WIDTH:0]     stretch_inc;
	logic                     wait_timeout;
	logic [RECOVER_W-1:0]     recover_inc;
	logic                     byte_done;

	logic                     res_valid_q;
	result_t                  res_q;
	logic                     step;

	// Advance one tick whenever the result slot is free or being drained
	assign step  = q_valid && (!res_valid_q || res.ready);
	assign q_pop = step;

	// Clock-stretch timer: timeout on the low sample that reaches the limit
	assign stretch_inc  = {1'b0, stretch_q} + 1'b1;
	assign wait_timeout = !q_item.scl &&
		((CMP_W'(stretch_inc) >= CMP_W'(stretch_limit)) || stretch_inc[TIMER_WIDTH]);
	assign recover_inc  = recover_q + 1'b1;
	assign byte_done    = (bit_cnt_q >= BITS_PER_BYTE);

	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		stretch_d  = stretch_q;
		recover_d  = recover_q;
		ack_flag_d = ack_flag_q;
		scl_out_d  = scl_out_q;
		sda_out_d  = sda_out_q;
		rx_hold_d  = rx_hold_q;
		fin_done   = 1'b0;
		fin_status = ST_OK;

		unique case (phase_q)
			PH_IDLE: begin
				unique case (q_item.cmd)
					CMD_START: begin
						sda_out_d = 1'b1;
						scl_out_d = 1'b1;
						stretch_d = '0;
						phase_d   = PH_ST_WAIT;
					end
					CMD_STOP: begin
						sda_out_d  = 1'b0;
						ack_flag_d = 1'b0;
						stretch_d  = '0;
						phase_d    = PH_SP_RAISE;
					end
					CMD_WRITE: begin
						shift_d    = q_item.tx_byte;
						bit_cnt_d  = '0;
						ack_flag_d = q_item.ack_check;
						stretch_d  = '0;
						sda_out_d  = q_item.tx_byte[BYTE_W-1];
						phase_d    = PH_W_RAISE;
					end
					CMD_READ: begin
						shift_d    = '0;
						bit_cnt_d  = '0;
						ack_flag_d = q_item.ack_after_read;
						stretch_d  = '0;
						sda_out_d  = 1'b1;
						phase_d    = PH_R_RAISE;
					end
					default: ;
				endcase
			end
			PH_ST_WAIT, PH_SP_WAIT, PH_W_WAIT, PH_R_WAIT: begin
				if (q_item.scl || wait_timeout)
					stretch_d = '0;
				else
					stretch_d = stretch_inc[TIMER_WIDTH-1:0];
				priority if (q_item.scl) begin
					unique case (phase_q)
						PH_ST_WAIT: phase_d = PH_ST_CHECK;
						PH_SP_WAIT: phase_d = PH_SP_REL;
						PH_W_WAIT:  phase_d = PH_W_LOW;
						default:    phase_d = PH_R_LOW;
					endcase
				end else if (wait_timeout) begin
					if (phase_q == PH_SP_WAIT) begin
						ack_flag_d = 1'b1;
						phase_d    = PH_SP_REL;
					end else begin
						if (phase_q == PH_R_WAIT && byte_done) begin
							scl_out_d = 1'b0;
							sda_out_d = 1'b1;
						end
						fin_done   = 1'b1;
						fin_status = ST_TIMEOUT;
						phase_d    = PH_IDLE;
					end
				end else begin
					phase_d = phase_q;
				end
			end
			PH_ST_CHECK, PH_RC_CHECK: begin
				priority if (q_item.sda) begin
					sda_out_d = 1'b0;
					phase_d   = PH_ST_SCL_LOW;
				end else if (phase_q == PH_ST_CHECK) begin
					sda_out_d = 1'b1;
					recover_d = '0;
					phase_d   = PH_RC_LOW;
				end else begin
					fin_done   = 1'b1;
					fin_status = ST_TIMEOUT;
					phase_d    = PH_IDLE;
				end
			end
			PH_ST_SCL_LOW: begin
				scl_out_d = 1'b0;
				fin_done  = 1'b1;
				phase_d   = PH_IDLE;
			end
			PH_RC_HIGH: begin
				scl_out_d = 1'b1;
				phase_d   = PH_RC_LOW;
			end
			PH_RC_LOW: begin
				scl_out_d = 1'b0;
				recover_d = recover_inc;
				phase_d   = (recover_inc >= RECOVER_W'(RECOVER_PULSES)) ? PH_RC_SDA_LOW
				                                                         : PH_RC_HIGH;
			end
			PH_RC_SDA_LOW: begin
				sda_out_d = 1'b0;
				phase_d   = PH_RC_SCL_UP;
			end
			PH_RC_SCL_UP: begin
				scl_out_d = 1'b1;
				phase_d   = PH_RC_SDA_UP;
			end
			PH_RC_SDA_UP: begin
				sda_out_d = 1'b1;
				phase_d   = PH_RC_CHECK;
			end
			PH_SP_RAISE, PH_W_RAISE, PH_R_RAISE: begin
				scl_out_d = 1'b1;
				unique case (phase_q)
					PH_SP_RAISE: phase_d = PH_SP_WAIT;
					PH_W_RAISE:  phase_d = PH_W_WAIT;
					default:     phase_d = PH_R_WAIT;
				endcase
			end
			PH_SP_REL: begin
				sda_out_d  = 1'b1;
				fin_done   = 1'b1;
				fin_status = ack_flag_q ? ST_TIMEOUT : ST_OK;
				phase_d    = PH_IDLE;
			end
			PH_W_LOW: begin
				scl_out_d = 1'b0;
				if (byte_done) begin
					fin_done   = 1'b1;
					fin_status = (ack_flag_q && q_item.sda) ? ST_NACK : ST_OK;
					phase_d    = PH_IDLE;
				end else begin
					bit_cnt_d = bit_cnt_q + 1'b1;
					shift_d   = {shift_q[BYTE_W-2:0], 1'b0};
					phase_d   = PH_W_DATA;
				end
			end
			PH_W_DATA: begin
				sda_out_d = byte_done ? 1'b1 : shift_q[BYTE_W-1];
				phase_d   = PH_W_RAISE;
			end
			PH_R_LOW: begin
				scl_out_d = 1'b0;
				if (byte_done) begin
					sda_out_d = 1'b1;
					rx_hold_d = shift_q;
					fin_done  = 1'b1;
					phase_d   = PH_IDLE;
				end else begin
					shift_d   = {shift_q[BYTE_W-2:0], q_item.sda};
					bit_cnt_d = bit_cnt_q + 1'b1;
					phase_d   = PH_R_DATA;
				end
			end
			PH_R_DATA: begin
				if (byte_done)
					sda_out_d = !ack_flag_q;
				phase_d = PH_R_RAISE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			stretch_q   <= '0;
			recover_q   <= '0;
			ack_flag_q  <= 1'b0;
			scl_out_q   <= 1'b1;
			sda_out_q   <= 1'b1;
			rx_hold_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q    <= phase_d;
				bit_cnt_q  <= bit_cnt_d;
				shift_q    <= shift_d;
				stretch_q  <= stretch_d;
				recover_q  <= recover_d;
				ack_flag_q <= ack_flag_d;
				scl_out_q  <= scl_out_d;
				sda_out_q  <= sda_out_d;
				rx_hold_q  <= rx_hold_d;
			end
			if (step)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	// Result register: loaded with the state after each tick
	always_ff @(posedge clk) begin
		if (step) begin
			res_q.scl_drive <= scl_out_d;
			res_q.sda_drive <= sda_out_d;
			res_q.ready_res <= (phase_d == PH_IDLE);
			res_q.done_res  <= fin_done;
			res_q.status    <= fin_status;
			res_q.rx_byte   <= rx_hold_d;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.scl_drive = res_q.scl_drive;
	assign res.sda_drive = res_q.sda_drive;
	assign res.ready_res = res_q.ready_res;
	assign res.done_res  = res_q.done_res;
	assign res.status    = res_q.status;
	assign res.rx_byte   = res_q.rx_byte;

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && fin_done |=> phase_q == PH_IDLE)
		else $error("completion without return to idle");

	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && fin_status != ST_OK |-> fin_done)
		else $error("status reported without completion");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> stretch_q == '0)
		else $error("stretch timer not cleared in idle");

endmodule

[tb/i2c_master_byte_engine_test.sv]
`timescale 1ns / 1ps

module i2c_master_byte_engine_test;
	import i2c_mbe_pkg::*;

	// Opcodes outside the command set; the engine treats them as a plain tick
	localparam logic [OPCODE_W-1:0] OP_UNKNOWN_LO = OP_READ + 1'b1;
	localparam logic [OPCODE_W-1:0] OP_UNKNOWN_HI = '1;

	localparam int              RECOVER_PULSES = DEF_RECOVER_PULSES;
	localparam longint unsigned TIMER_MAX      = (64'd1 << DEF_TIMER_WIDTH) - 1;
	localparam int              STALL_LIMIT    = 2000;
	localparam int              SETTLE_CYCLES  = 6;
	localparam int              TICKS_PER_RUN  = 180;
	localparam int              NUM_RUNS       = 7;
	localparam int              SCRIPT_LEN     = 16;

	// Stretch limits visited by the random runs; the run at STEADY_RUN has no gaps
	localparam logic [LIMIT_W-1:0] LIMIT_PLAN [NUM_RUNS] =
		'{16'd1, 16'd3, 16'hFFFF, 16'd0, 16'd2, 16'd8, 16'd500};
	localparam int STEADY_RUN = 2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BYTE_W-1:0]   tx_byte;
		logic                ack_check;
		logic                ack_after_read;
		logic                scl;
		logic                sda;
	} tick_t;

	localparam int TICK_W = $bits(tick_t);

	typedef struct packed {
		tick_t   stim;
		logic    typed;
		result_t want;
	} script_row_t;

	typedef enum logic [1:0] {WAIT_HOLD, WAIT_SEEN, WAIT_EXPIRED} scl_wait_t;

	localparam result_t IDLE_RES = '{1'b1, 1'b1, 1'b1, 1'b0, ST_OK, 8'h00};
	localparam result_t NO_RES   = '0;

	// Directed opening: idle ticks, unknown opcodes, a clean start and stop,
	// then a write of all ones with commands thrown at the busy engine and a
	// short clock stretch. The random part picks up the write where this ends.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, IDLE_RES},
		'{'{OP_UNKNOWN_LO, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, IDLE_RES},
		'{'{OP_UNKNOWN_HI, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, IDLE_RES},
		'{'{OP_START,      8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b0, 1'b0, 1'b1, 1'b1, ST_OK, 8'h00}},
		'{'{OP_STOP,       8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b1, 1'b1, 1'b1, 1'b1, ST_OK, 8'h00}},
		'{'{OP_WRITE,      8'hFF, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_READ,       8'h00, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_STOP,       8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RES},
		'{'{OP_TICK,       8'h00, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_START,      8'hA5, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RES}
	};

	bit                 clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	i2c_mbe_cmd_if cmd_ch ();
	i2c_mbe_res_if res_ch ();

	i2c_master_byte_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Bus engine mirror: phase, counters and pin drives as the block should hold them
	phase_t                 ph;
	logic [BIT_CNT_W-1:0]   bit_cnt;
	logic [BYTE_W-1:0]      shift_q;
	longint unsigned        stretch_cnt;
	logic [RECOVER_W-1:0]   recover_cnt;
	logic                   ack_flag;
	logic                   scl_q;
	logic                   sda_q;
	logic [BYTE_W-1:0]      rx_hold;
	logic [LIMIT_W-1:0]     stretch_limit_q;

	// Target-side stimulus state
	logic                   in_wait;
	int                     stretch_left;
	logic [BYTE_W-1:0]      target_byte;

	result_t                bus_expect_q [$];
	int                     mismatches = 0;
	int                     quiet_cycles = 0;
	logic                   steady;

	initial begin
		forever #5 clk = ~clk;
	end

	// Count SCL-low samples while waiting for the clock to come back high
	function automatic scl_wait_t clock_wait(input logic scl);
		longint unsigned next_cnt;
		if (scl) begin
			stretch_cnt = 0;
			return WAIT_SEEN;
		end
		next_cnt = stretch_cnt + 1;
		if (next_cnt >= stretch_limit_q || next_cnt > TIMER_MAX) begin
			stretch_cnt = 0;
			return WAIT_EXPIRED;
		end
		stretch_cnt = next_cnt;
		return WAIT_HOLD;
	endfunction

	// Advance the mirror by one half-period tick and return the pin/status view
	function automatic result_t bus_step(input tick_t t);
		result_t           r;
		logic              fin;
		logic [STATUS_W-1:0] st;
		scl_wait_t         w;
		fin = 1'b0;
		st  = ST_OK;
		case (ph)
			PH_IDLE: begin
				case (t.opcode)
					OP_START: begin
						sda_q = 1'b1; scl_q = 1'b1; stretch_cnt = 0;
						ph = PH_ST_WAIT;
					end
					OP_STOP: begin
						sda_q = 1'b0; ack_flag = 1'b0; stretch_cnt = 0;
						ph = PH_SP_RAISE;
					end
					OP_WRITE: begin
						shift_q = t.tx_byte; bit_cnt = '0; ack_flag = t.ack_check;
						stretch_cnt = 0; sda_q = t.tx_byte[BYTE_W-1];
						ph = PH_W_RAISE;
					end
					OP_READ: begin
						shift_q = '0; bit_cnt = '0; ack_flag = t.ack_after_read;
						stretch_cnt = 0; sda_q = 1'b1;
						ph = PH_R_RAISE;
					end
					default: ;
				endcase
			end
			PH_ST_WAIT: begin
				w = clock_wait(t.scl);
				if (w == WAIT_SEEN) begin
					ph = PH_ST_CHECK;
				end else if (w == WAIT_EXPIRED) begin
					fin = 1'b1; st = ST_TIMEOUT;
				end
			end
			PH_ST_CHECK: begin
				if (t.sda) begin
					sda_q = 1'b0;
					ph = PH_ST_SCL_LOW;
				end else begin
					sda_q = 1'b1; recover_cnt = '0;
					ph = PH_RC_LOW;
				end
			end
			PH_ST_SCL_LOW: begin
				scl_q = 1'b0;
				fin = 1'b1;
			end
			PH_RC_HIGH: begin
				scl_q = 1'b1;
				ph = PH_RC_LOW;
			end
			PH_RC_LOW: begin
				scl_q = 1'b0;
				recover_cnt = recover_cnt + 1'b1;
				ph = (recover_cnt >= RECOVER_PULSES) ? PH_RC_SDA_LOW : PH_RC_HIGH;
			end
			PH_RC_SDA_LOW: begin
				sda_q = 1'b0;
				ph = PH_RC_SCL_UP;
			end
			PH_RC_SCL_UP: begin
				scl_q = 1'b1;
				ph = PH_RC_SDA_UP;
			end
			PH_RC_SDA_UP: begin
				sda_q = 1'b1;
				ph = PH_RC_CHECK;
			end
			PH_RC_CHECK: begin
				if (t.sda) begin
					sda_q = 1'b0;
					ph = PH_ST_SCL_LOW;
				end else begin
					fin = 1'b1; st = ST_TIMEOUT;
				end
			end
			PH_SP_RAISE: begin
				scl_q = 1'b1;
				ph = PH_SP_WAIT;
			end
			PH_SP_WAIT: begin
				w = clock_wait(t.scl);
				if (w == WAIT_EXPIRED) ack_flag = 1'b1;
				if (w != WAIT_HOLD) ph = PH_SP_REL;
			end
			PH_SP_REL: begin
				sda_q = 1'b1;
				fin = 1'b1; st = ack_flag ? ST_TIMEOUT : ST_OK;
			end
			PH_W_RAISE: begin
				scl_q = 1'b1;
				ph = PH_W_WAIT;
			end
			PH_W_WAIT: begin
				w = clock_wait(t.scl);
				if (w == WAIT_SEEN) begin
					ph = PH_W_LOW;
				end else if (w == WAIT_EXPIRED) begin
					fin = 1'b1; st = ST_TIMEOUT;
				end
			end
			PH_W_LOW: begin
				scl_q = 1'b0;
				if (bit_cnt >= BITS_PER_BYTE) begin
					fin = 1'b1; st = (ack_flag && t.sda) ? ST_NACK : ST_OK;
				end else begin
					bit_cnt = bit_cnt + 1'b1;
					shift_q = shift_q << 1;
					ph = PH_W_DATA;
				end
			end
			PH_W_DATA: begin
				sda_q = (bit_cnt >= BITS_PER_BYTE) ? 1'b1 : shift_q[BYTE_W-1];
				ph = PH_W_RAISE;
			end
			PH_R_RAISE: begin
				scl_q = 1'b1;
				ph = PH_R_WAIT;
			end
			PH_R_WAIT: begin
				w = clock_wait(t.scl);
				if (w == WAIT_SEEN) begin
					ph = PH_R_LOW;
				end else if (w == WAIT_EXPIRED) begin
					// a timeout on the acknowledge bit parks SCL low, SDA released
					if (bit_cnt >= BITS_PER_BYTE) begin
						scl_q = 1'b0; sda_q = 1'b1;
					end
					fin = 1'b1; st = ST_TIMEOUT;
				end
			end
			PH_R_LOW: begin
				scl_q = 1'b0;
				if (bit_cnt >= BITS_PER_BYTE) begin
					sda_q = 1'b1;
					rx_hold = shift_q;
					fin = 1'b1;
				end else begin
					shift_q = {shift_q[BYTE_W-2:0], t.sda};
					bit_cnt = bit_cnt + 1'b1;
					ph = PH_R_DATA;
				end
			end
			PH_R_DATA: begin
				if (bit_cnt >= BITS_PER_BYTE) sda_q = ~ack_flag;
				ph = PH_R_RAISE;
			end
			default: ph = PH_IDLE;
		endcase
		if (fin) ph = PH_IDLE;
		r.scl_drive = scl_q;
		r.sda_drive = sda_q;
		r.ready_res = (ph == PH_IDLE);
		r.done_res  = fin;
		r.status    = st;
		r.rx_byte   = rx_hold;
		return r;
	endfunction

	// Build the next tick as a well-behaved target would answer the engine,
	// with clock stretching, stuck data lines and the odd fully random tick.
	function automatic tick_t make_tick();
		tick_t t;
		int    roll;
		logic  waiting;
		waiting = 1'b0;
		t = TICK_W'($urandom);
		case (ph)
			PH_IDLE: begin
				roll = $urandom_range(99);
				if (roll < 25)      t.opcode = OP_START;
				else if (roll < 50) t.opcode = OP_WRITE;
				else if (roll < 72) t.opcode = OP_READ;
				else if (roll < 87) t.opcode = OP_STOP;
				else if (roll < 95) t.opcode = OP_TICK;
				else t.opcode = OPCODE_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
				// lean on the all-zero and all-one bytes in both directions
				roll = $urandom_range(99);
				if (roll < 20)      t.tx_byte = '0;
				else if (roll < 40) t.tx_byte = '1;
				roll = $urandom_range(99);
				if (roll < 20)      target_byte = '0;
				else if (roll < 40) target_byte = '1;
				else                target_byte = BYTE_W'($urandom);
			end
			PH_ST_WAIT, PH_SP_WAIT, PH_W_WAIT, PH_R_WAIT: begin
				waiting = 1'b1;
				if (!in_wait) begin
					roll = $urandom_range(99);
					if (roll < 65)                 stretch_left = 0;
					else if (roll < 92)            stretch_left = $urandom_range(1, 3);
					else if (stretch_limit_q <= 16) stretch_left = $urandom_range(0, stretch_limit_q + 1);
					else                           stretch_left = $urandom_range(4, 12);
				end
				t.scl = (stretch_left == 0);
				if (stretch_left != 0) stretch_left--;
			end
			PH_ST_CHECK: t.sda = ($urandom_range(99) < 85);
			PH_RC_CHECK: t.sda = ($urandom_range(99) < 70);
			PH_W_LOW:    if (bit_cnt >= BITS_PER_BYTE) t.sda = ($urandom_range(99) < 25);
			PH_R_LOW: begin
				t.sda = target_byte[BYTE_W-1];
				target_byte = target_byte << 1;
			end
			default: ;
		endcase
		in_wait = waiting;
		if ($urandom_range(99) < 8) t = TICK_W'($urandom);
		return t;
	endfunction

	// Present one tick, hold it until the engine takes the transfer, then
	// log the expected result. Returns on the falling edge after the transfer.
	task automatic send_tick(input tick_t t, input logic typed, input result_t want);
		result_t predicted;
		while (!steady && $urandom_range(99) < 18) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.opcode         <= t.opcode;
		cmd_ch.tx_byte        <= t.tx_byte;
		cmd_ch.ack_check      <= t.ack_check;
		cmd_ch.ack_after_read <= t.ack_after_read;
		cmd_ch.scl_sampled    <= t.scl;
		cmd_ch.sda_sampled    <= t.sda;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = bus_step(t);
		bus_expect_q.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has drained
	task automatic quiesce();
		cmd_ch.valid <= 1'b0;
		while (bus_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side: random back-pressure, held off during the steady run
	always @(negedge clk) begin
		res_ch.ready <= steady || ($urandom_range(99) >= 18);
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (bus_expect_q.size() == 0) begin
				$error("result transfer with no expectation pending");
				mismatches++;
			end else begin
				want = bus_expect_q.pop_front();
				if (res_ch.scl_drive !== want.scl_drive) begin
					$error("scl_drive: expected %0d, got %0d", want.scl_drive, res_ch.scl_drive);
					mismatches++;
				end
				if (res_ch.sda_drive !== want.sda_drive) begin
					$error("sda_drive: expected %0d, got %0d", want.sda_drive, res_ch.sda_drive);
					mismatches++;
				end
				if (res_ch.ready_res !== want.ready_res) begin
					$error("ready_res: expected %0d, got %0d", want.ready_res, res_ch.ready_res);
					mismatches++;
				end
				if (res_ch.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, res_ch.done_res);
					mismatches++;
				end
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					mismatches++;
				end
				if (res_ch.rx_byte !== want.rx_byte) begin
					$error("rx_byte: expected 0x%02h, got 0x%02h", want.rx_byte, res_ch.rx_byte);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves a transfer for too long
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		// Drive every input to a known level before the first edge
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.opcode         = OP_TICK;
		cmd_ch.tx_byte        = '0;
		cmd_ch.ack_check      = 1'b0;
		cmd_ch.ack_after_read = 1'b0;
		cmd_ch.scl_sampled    = 1'b1;
		cmd_ch.sda_sampled    = 1'b1;
		steady                = 1'b0;

		// Reset state of the mirror
		ph              = PH_IDLE;
		bit_cnt         = '0;
		shift_q         = '0;
		stretch_cnt     = 0;
		recover_cnt     = '0;
		ack_flag        = 1'b0;
		scl_q           = 1'b1;
		sda_q           = 1'b1;
		rx_hold         = '0;
		stretch_limit_q = LIMIT_RESET;
		in_wait         = 1'b0;
		stretch_left    = 0;
		target_byte     = '0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part runs with the limit as it comes out of reset
		foreach (SCRIPT[i]) send_tick(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want);

		// Random runs, one per stretch limit; reprogram only once the engine drained
		for (int run = 0; run < NUM_RUNS; run++) begin
			quiesce();
			cfg_we          <= 1'b1;
			cfg_wdata       <= LIMIT_PLAN[run];
			stretch_limit_q = LIMIT_PLAN[run];
			steady          <= (run == STEADY_RUN);
			@(negedge clk);
			cfg_we <= 1'b0;
			repeat (TICKS_PER_RUN) send_tick(make_tick(), 1'b0, NO_RES);
		end

		quiesce();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
